FILE: sv/gdt_pkg.sv
// Shared types, constants and helpers of the graph traversal unit.
package gdt_pkg;

  localparam int MaxVertices = 64;
  localparam int VtxW        = 6;
  localparam int CntW        = 7;
  localparam int ListDepth   = 64;

  typedef enum logic [1:0] {
    CMD_ADD_EDGE = 2'd0,
    CMD_DFS      = 2'd1,
    CMD_BFS      = 2'd2,
    CMD_REMOVE   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RA,
    ST_ADD_WA,
    ST_ADD_RB,
    ST_ADD_WB,
    ST_REM,
    ST_SCAN,
    ST_DFS_START,
    ST_DFS_RD,
    ST_DFS_EV,
    ST_BFS_START,
    ST_BFS_QRD,
    ST_BFS_ARD,
    ST_BFS_PUSH,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]      command;
    logic [VtxW-1:0] vertex_a;
    logic [VtxW-1:0] vertex_b;
  } in_word_t;

  typedef struct packed {
    logic [VtxW-1:0] visited_vertex;
    logic            last_of_run;
  } out_word_t;

  typedef struct packed {
    logic            push;
    logic            flush;
    logic [VtxW-1:0] vtx;
  } emit_ctl_t;

  function automatic logic [VtxW-1:0] lowest_bit(input logic [MaxVertices-1:0] m);
    logic [VtxW-1:0] r;
    r = '0;
    for (int i = MaxVertices - 1; i >= 0; i--) begin
      if (m[i]) r = VtxW'(i);
    end
    return r;
  endfunction

endpackage

FILE: sv/gdt_adj_mem.sv
// Adjacency row memory with per-row valid bits, one read and one write port.
module gdt_adj_mem #(
  parameter int NV = gdt_pkg::MaxVertices,
  parameter int AW = $clog2(NV)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [NV-1:0] wr_data,
  output logic [NV-1:0] rd_data
);

  logic [NV-1:0] mem [NV];
  logic [NV-1:0] row_valid_r;
  logic [NV-1:0] rd_q_r;
  logic          rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (wr_en) row_valid_r[wr_addr] <= 1'b1;
      if (rd_en) rd_vld_r <= row_valid_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

FILE: sv/gdt_list_mem.sv
// Work list memory holding the depth-first stack or the breadth-first queue.
module gdt_list_mem #(
  parameter int DEPTH = gdt_pkg::ListDepth,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [gdt_pkg::VtxW-1:0] wr_data,
  output logic [gdt_pkg::VtxW-1:0] rd_data
);

  logic [gdt_pkg::VtxW-1:0] mem [DEPTH];
  logic [gdt_pkg::VtxW-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  assign rd_data = rd_q_r;

endmodule

FILE: sv/gdt_out.sv
// Result stage: holds one pending vertex so the last one of a run can be flagged.
module gdt_out (
  input  logic               clk,
  input  logic               rst_n,
  input  gdt_pkg::emit_ctl_t emit,
  output logic               emit_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output gdt_pkg::out_word_t out_data
);

  logic                     pend_valid_r, pend_valid_nxt;
  logic [gdt_pkg::VtxW-1:0] pend_vtx_r, pend_vtx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  gdt_pkg::out_word_t       out_word_r, out_word_nxt;
  logic                     slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign emit_ok   = !pend_valid_r || slot_free;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_vtx_nxt   = pend_vtx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_word_nxt   = out_word_r;
    if (emit.push && emit_ok) begin
      if (pend_valid_r) begin
        out_valid_nxt            = 1'b1;
        out_word_nxt.visited_vertex = pend_vtx_r;
        out_word_nxt.last_of_run = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_vtx_nxt   = emit.vtx;
    end else if (emit.flush && emit_ok && pend_valid_r) begin
      out_valid_nxt               = 1'b1;
      out_word_nxt.visited_vertex = pend_vtx_r;
      out_word_nxt.last_of_run    = 1'b1;
      pend_valid_nxt              = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_vtx_r <= pend_vtx_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

FILE: sv/graph_dfs_bfs_traversal.sv
// Top level of the graph traversal unit: command sequencer and flag registers.
// Usage:
//   in_*  : command words (add edge, depth-first, breadth-first, remove vertex).
//           in_ready is high only while the sequencer is idle.
//   out_* : one word per emitted vertex; last_of_run marks the final one.
//   cfg_* : vertex_count register, ready only while idle and no command is offered.
// Sequencing:
//   add edge makes two read-modify-write passes on the adjacency memory
//   (row of vertex_a, then row of vertex_b); remove vertex clears one row.
//   A traversal scans for each unvisited start vertex; depth-first then
//   reads the current row and the stack, then pushes or pops; breadth-first
//   reads a queue entry, its row, then enqueues each neighbor. A flush ends it.
//   Each result word leaves one vertex after it is found; the last one leaves
//   when the traversal ends.
// Reset: graph empty, no vertex removed, vertex_count 64. Row valid bits clear
//   the adjacency memory at once; no clearing pass.
// Stall: a held output word stalls the sequencer once one further vertex is
//   pending; nothing is dropped.
module graph_dfs_bfs_traversal #(
  parameter int MAX_VERTICES = gdt_pkg::MaxVertices
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  gdt_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gdt_pkg::out_word_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gdt_pkg::CntW-1:0]    cfg_vertex_count
);

  localparam int NV = MAX_VERTICES;
  localparam int AW = $clog2(NV);
  localparam int VW = gdt_pkg::VtxW;
  localparam int CW = gdt_pkg::CntW;
  localparam logic [NV-1:0] OneBit = {{(NV-1){1'b0}}, 1'b1};

  gdt_pkg::state_t    state_r, state_nxt;
  gdt_pkg::in_word_t  item_r, item_nxt;
  logic [CW-1:0]      vc_r;
  logic [NV-1:0]      visited_r, visited_nxt;
  logic [NV-1:0]      removed_r, removed_nxt;
  logic [CW-1:0]      start_r, start_nxt;
  logic [CW-1:0]      back_r, back_nxt;
  logic [CW-1:0]      front_r, front_nxt;
  logic [VW-1:0]      cur_r, cur_nxt;

  logic [CW-1:0]      cnt;
  logic               in_fire;
  logic               stall;
  logic               emit_ok;
  gdt_pkg::emit_ctl_t emit;

  logic               adj_rd_en, adj_wr_en;
  logic [AW-1:0]      adj_rd_addr, adj_wr_addr;
  logic [NV-1:0]      adj_wr_data, adj_rd_data;
  logic               lst_rd_en, lst_wr_en;
  logic [AW-1:0]      lst_rd_addr, lst_wr_addr;
  logic [VW-1:0]      lst_wr_data, lst_rd_data;

  logic [NV-1:0]      cand;
  logic [VW-1:0]      nb;
  logic [CW-1:0]      back_m2;

  assign cnt       = (vc_r > CW'(NV)) ? CW'(NV) : vc_r;
  assign in_ready  = (state_r == gdt_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = in_ready && !in_valid;
  assign cand      = (removed_r[cur_r[AW-1:0]] ? '0 : adj_rd_data) & ~visited_r;
  assign nb        = gdt_pkg::lowest_bit(gdt_pkg::MaxVertices'(cand));
  assign back_m2   = back_r - CW'(2);
  assign stall     = (emit.push || emit.flush) && !emit_ok;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gdt_pkg::ST_IDLE: begin
        if (in_fire) begin
          priority case (in_data.command)
            gdt_pkg::CMD_ADD_EDGE:
              if (({1'b0, in_data.vertex_a} < cnt) && ({1'b0, in_data.vertex_b} < cnt))
                state_nxt = gdt_pkg::ST_ADD_RA;
            gdt_pkg::CMD_REMOVE:
              if ({1'b0, in_data.vertex_a} < CW'(NV)) state_nxt = gdt_pkg::ST_REM;
            default: state_nxt = gdt_pkg::ST_SCAN;
          endcase
        end
      end
      gdt_pkg::ST_ADD_RA: state_nxt = gdt_pkg::ST_ADD_WA;
      gdt_pkg::ST_ADD_WA: state_nxt = gdt_pkg::ST_ADD_RB;
      gdt_pkg::ST_ADD_RB: state_nxt = gdt_pkg::ST_ADD_WB;
      gdt_pkg::ST_ADD_WB: state_nxt = gdt_pkg::ST_IDLE;
      gdt_pkg::ST_REM:    state_nxt = gdt_pkg::ST_IDLE;
      gdt_pkg::ST_SCAN: begin
        if (start_r >= cnt) state_nxt = gdt_pkg::ST_FLUSH;
        else if (!visited_r[start_r[AW-1:0]])
          state_nxt = (item_r.command == gdt_pkg::CMD_DFS) ?
                      gdt_pkg::ST_DFS_START : gdt_pkg::ST_BFS_START;
      end
      gdt_pkg::ST_DFS_START: if (!stall) state_nxt = gdt_pkg::ST_DFS_RD;
      gdt_pkg::ST_DFS_RD:    state_nxt = gdt_pkg::ST_DFS_EV;
      gdt_pkg::ST_DFS_EV: begin
        if (cand != '0) begin
          if (!stall) state_nxt = gdt_pkg::ST_DFS_RD;
        end else begin
          state_nxt = (back_r == CW'(1)) ? gdt_pkg::ST_SCAN : gdt_pkg::ST_DFS_RD;
        end
      end
      gdt_pkg::ST_BFS_START: state_nxt = gdt_pkg::ST_BFS_QRD;
      gdt_pkg::ST_BFS_QRD:
        state_nxt = (front_r < back_r) ? gdt_pkg::ST_BFS_ARD : gdt_pkg::ST_SCAN;
      gdt_pkg::ST_BFS_ARD:  if (!stall) state_nxt = gdt_pkg::ST_BFS_PUSH;
      gdt_pkg::ST_BFS_PUSH: if (cand == '0) state_nxt = gdt_pkg::ST_BFS_QRD;
      gdt_pkg::ST_FLUSH:    if (!stall) state_nxt = gdt_pkg::ST_IDLE;
      default: state_nxt = gdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_nxt    = item_r;
    visited_nxt = visited_r;
    removed_nxt = removed_r;
    start_nxt   = start_r;
    back_nxt    = back_r;
    front_nxt   = front_r;
    cur_nxt     = cur_r;
    emit        = '0;
    adj_rd_en   = 1'b0;
    adj_rd_addr = cur_r[AW-1:0];
    adj_wr_en   = 1'b0;
    adj_wr_addr = item_r.vertex_a[AW-1:0];
    adj_wr_data = '0;
    lst_rd_en   = 1'b0;
    lst_rd_addr = front_r[AW-1:0];
    lst_wr_en   = 1'b0;
    lst_wr_addr = back_r[AW-1:0];
    lst_wr_data = nb;
    unique case (state_r)
      gdt_pkg::ST_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          if (in_data.command == gdt_pkg::CMD_DFS || in_data.command == gdt_pkg::CMD_BFS) begin
            visited_nxt = '0;
            start_nxt   = '0;
          end
        end
      end
      gdt_pkg::ST_ADD_RA: begin
        adj_rd_en   = 1'b1;
        adj_rd_addr = item_r.vertex_a[AW-1:0];
      end
      gdt_pkg::ST_ADD_WA: begin
        adj_wr_en   = 1'b1;
        adj_wr_addr = item_r.vertex_a[AW-1:0];
        adj_wr_data = adj_rd_data | (OneBit << item_r.vertex_b[AW-1:0]);
        removed_nxt = removed_r & ~(OneBit << item_r.vertex_a[AW-1:0])
                                & ~(OneBit << item_r.vertex_b[AW-1:0]);
      end
      gdt_pkg::ST_ADD_RB: begin
        adj_rd_en   = 1'b1;
        adj_rd_addr = item_r.vertex_b[AW-1:0];
      end
      gdt_pkg::ST_ADD_WB: begin
        adj_wr_en   = 1'b1;
        adj_wr_addr = item_r.vertex_b[AW-1:0];
        adj_wr_data = adj_rd_data | (OneBit << item_r.vertex_a[AW-1:0]);
      end
      gdt_pkg::ST_REM: begin
        adj_wr_en   = 1'b1;
        adj_wr_addr = item_r.vertex_a[AW-1:0];
        adj_wr_data = '0;
        removed_nxt = removed_r | (OneBit << item_r.vertex_a[AW-1:0]);
      end
      gdt_pkg::ST_SCAN: begin
        if (start_r < cnt && visited_r[start_r[AW-1:0]]) start_nxt = start_r + CW'(1);
      end
      gdt_pkg::ST_DFS_START: begin
        emit.push = !removed_r[start_r[AW-1:0]];
        emit.vtx  = start_r[VW-1:0];
        if (!emit.push || emit_ok) begin
          visited_nxt = visited_r | (OneBit << start_r[AW-1:0]);
          lst_wr_en   = 1'b1;
          lst_wr_addr = '0;
          lst_wr_data = start_r[VW-1:0];
          back_nxt    = CW'(1);
          cur_nxt     = start_r[VW-1:0];
        end
      end
      gdt_pkg::ST_DFS_RD: begin
        adj_rd_en   = 1'b1;
        adj_rd_addr = cur_r[AW-1:0];
        lst_rd_en   = 1'b1;
        lst_rd_addr = back_m2[AW-1:0];
      end
      gdt_pkg::ST_DFS_EV: begin
        if (cand != '0) begin
          emit.push = !removed_r[nb[AW-1:0]];
          emit.vtx  = nb;
          if (!emit.push || emit_ok) begin
            visited_nxt = visited_r | (OneBit << nb[AW-1:0]);
            lst_wr_en   = 1'b1;
            lst_wr_addr = back_r[AW-1:0];
            back_nxt    = back_r + CW'(1);
            cur_nxt     = nb;
          end
        end else begin
          back_nxt = back_r - CW'(1);
          cur_nxt  = lst_rd_data;
          if (back_r == CW'(1)) start_nxt = start_r + CW'(1);
        end
      end
      gdt_pkg::ST_BFS_START: begin
        visited_nxt = visited_r | (OneBit << start_r[AW-1:0]);
        lst_wr_en   = 1'b1;
        lst_wr_addr = '0;
        lst_wr_data = start_r[VW-1:0];
        back_nxt    = CW'(1);
        front_nxt   = '0;
      end
      gdt_pkg::ST_BFS_QRD: begin
        if (front_r < back_r) begin
          lst_rd_en   = 1'b1;
          lst_rd_addr = front_r[AW-1:0];
        end else begin
          start_nxt = start_r + CW'(1);
        end
      end
      gdt_pkg::ST_BFS_ARD: begin
        emit.push = !removed_r[lst_rd_data[AW-1:0]];
        emit.vtx  = lst_rd_data;
        if (!emit.push || emit_ok) begin
          adj_rd_en   = 1'b1;
          adj_rd_addr = lst_rd_data[AW-1:0];
          front_nxt   = front_r + CW'(1);
          cur_nxt     = lst_rd_data;
        end
      end
      gdt_pkg::ST_BFS_PUSH: begin
        if (cand != '0) begin
          visited_nxt = visited_r | (OneBit << nb[AW-1:0]);
          lst_wr_en   = 1'b1;
          lst_wr_addr = back_r[AW-1:0];
          back_nxt    = back_r + CW'(1);
        end
      end
      gdt_pkg::ST_FLUSH: emit.flush = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= gdt_pkg::ST_IDLE;
      vc_r      <= CW'(gdt_pkg::MaxVertices);
      visited_r <= '0;
      removed_r <= '0;
      start_r   <= '0;
      back_r    <= '0;
      front_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_valid && cfg_ready) vc_r <= cfg_vertex_count;
      visited_r <= visited_nxt;
      removed_r <= removed_nxt;
      start_r   <= start_nxt;
      back_r    <= back_nxt;
      front_r   <= front_nxt;
    end
    item_r <= item_nxt;
    cur_r  <= cur_nxt;
  end

  gdt_adj_mem #(.NV(NV), .AW(AW)) u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (adj_rd_en),
    .rd_addr (adj_rd_addr),
    .wr_en   (adj_wr_en),
    .wr_addr (adj_wr_addr),
    .wr_data (adj_wr_data),
    .rd_data (adj_rd_data)
  );

  gdt_list_mem #(.DEPTH(NV), .AW(AW)) u_list (
    .clk     (clk),
    .rd_en   (lst_rd_en),
    .rd_addr (lst_rd_addr),
    .wr_en   (lst_wr_en),
    .wr_addr (lst_wr_addr),
    .wr_data (lst_wr_data),
    .rd_data (lst_rd_data)
  );

  gdt_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .emit_ok   (emit_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_back_bound: assert property (@(posedge clk) disable iff (!rst_n)
    back_r <= CW'(NV))
    else $error("work list overflow");

  a_front_le_back: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdt_pkg::ST_BFS_QRD || state_r == gdt_pkg::ST_BFS_ARD ||
     state_r == gdt_pkg::ST_BFS_PUSH) |-> front_r <= back_r)
    else $error("queue front passed back");

  a_push_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == gdt_pkg::ST_DFS_EV || state_r == gdt_pkg::ST_BFS_PUSH) && cand != '0)
      |-> !visited_r[nb[AW-1:0]])
    else $error("pushed a visited vertex");

  a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdt_pkg::ST_IDLE) |-> !emit.push && !emit.flush)
    else $error("emit outside a traversal");
`endif

endmodule

FILE: sim/graph_dfs_bfs_traversal_test.sv
// Testbench for the graph traversal unit: directed table, random phases, predictor check.
`timescale 1ns / 1ps
module graph_dfs_bfs_traversal_test;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  gdt_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gdt_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gdt_pkg::CntW-1:0] cfg_vertex_count = '0;

  graph_dfs_bfs_traversal dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_vertex_count(cfg_vertex_count)
  );

  always #10 clk = ~clk;

  typedef struct {
    gdt_pkg::in_word_t  word;
    bit                 typed;
    gdt_pkg::out_word_t first_result;
  } dir_row_t;

  logic [63:0] adj_rows [gdt_pkg::MaxVertices];
  logic [63:0] removed_set;
  logic [63:0] seen_set;
  logic [6:0]  span_count;
  gdt_pkg::out_word_t pending_visits [$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_recv = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH %s at %0t", what, $realtime);
    error_count++;
  endtask

  function automatic int trav_count();
    return (int'(span_count) > gdt_pkg::MaxVertices) ? gdt_pkg::MaxVertices
                                                     : int'(span_count);
  endfunction

  function automatic int first_set(input logic [63:0] m);
    for (int i = 0; i < 64; i++) if (m[i]) return i;
    return 0;
  endfunction

  function automatic void note_visit(input int v, ref gdt_pkg::out_word_t found[$]);
    seen_set[v] = 1'b1;
    if (!removed_set[v] && found.size() < 64) begin
      found.push_back('{visited_vertex: v[5:0], last_of_run: 1'b0});
    end
  endfunction

  function automatic logic [63:0] open_row(input int v);
    return removed_set[v] ? 64'd0 : adj_rows[v];
  endfunction

  function automatic void predict_word(input gdt_pkg::in_word_t w);
    int cnt;
    int a;
    int b;
    int stack_q [$];
    int top;
    logic [63:0] cand;
    gdt_pkg::out_word_t found [$];
    cnt = trav_count();
    a = int'(w.vertex_a);
    b = int'(w.vertex_b);
    case (gdt_pkg::cmd_t'(w.command))
      gdt_pkg::CMD_ADD_EDGE: begin
        if (a < cnt && b < cnt) begin
          adj_rows[a][b] = 1'b1;
          adj_rows[b][a] = 1'b1;
          removed_set[a] = 1'b0;
          removed_set[b] = 1'b0;
        end
      end
      gdt_pkg::CMD_REMOVE: begin
        adj_rows[a] = '0;
        removed_set[a] = 1'b1;
      end
      default: begin
        seen_set = '0;
        for (int s = 0; s < cnt; s++) begin
          if (seen_set[s]) continue;
          stack_q.delete();
          if (w.command == gdt_pkg::CMD_DFS) begin
            note_visit(s, found);
            stack_q.push_back(s);
            while (stack_q.size() > 0) begin
              top = stack_q[$];
              cand = open_row(top) & ~seen_set;
              if (cand != 0 && stack_q.size() < 64) begin
                top = first_set(cand);
                note_visit(top, found);
                stack_q.push_back(top);
              end else begin
                void'(stack_q.pop_back());
              end
            end
          end else begin
            seen_set[s] = 1'b1;
            stack_q.push_back(s);
            for (int f = 0; f < stack_q.size(); f++) begin
              top = stack_q[f];
              note_visit(top, found);
              cand = open_row(top) & ~seen_set;
              while (cand != 0 && stack_q.size() < 64) begin
                b = first_set(cand);
                cand &= cand - 1;
                seen_set[b] = 1'b1;
                stack_q.push_back(b);
              end
            end
          end
        end
        if (found.size() > 0) found[$].last_of_run = 1'b1;
        foreach (found[i]) pending_visits.push_back(found[i]);
      end
    endcase
  endfunction

  task automatic send_word(input gdt_pkg::in_word_t w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(w);
    @(negedge clk);
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_visits.size() > 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_count(input logic [gdt_pkg::CntW-1:0] c);
    cfg_valid <= 1'b1;
    cfg_vertex_count <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    span_count = c;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic gdt_pkg::in_word_t rand_word(input int cnt);
    gdt_pkg::in_word_t w;
    int r;
    int hi;
    hi = (cnt < 1) ? 0 : cnt - 1;
    r = $urandom_range(99);
    w.command = (r < 55) ? gdt_pkg::CMD_ADD_EDGE : (r < 70) ? gdt_pkg::CMD_DFS :
                (r < 85) ? gdt_pkg::CMD_BFS : gdt_pkg::CMD_REMOVE;
    if ($urandom_range(9) == 0) begin
      w.vertex_a = 6'($urandom);
      w.vertex_b = 6'($urandom);
    end else begin
      w.vertex_a = 6'($urandom_range(hi));
      w.vertex_b = 6'($urandom_range(hi));
    end
    return w;
  endfunction

  always @(negedge clk) begin
    if (hold_recv) out_ready <= 1'b0;
    else if (recv_stall_pct > 0) out_ready <= ($urandom_range(99) >= recv_stall_pct);
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    gdt_pkg::out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_visits.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d", out_data.visited_vertex));
      end else begin
        exp_w = pending_visits.pop_front();
        if (out_data.visited_vertex !== exp_w.visited_vertex)
          report_mismatch($sformatf("vertex got %0d want %0d",
                                    out_data.visited_vertex, exp_w.visited_vertex));
        if (out_data.last_of_run !== exp_w.last_of_run)
          report_mismatch($sformatf("last flag got %0b want %0b",
                                    out_data.last_of_run, exp_w.last_of_run));
      end
    end
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    dir_row_t dir_rows [$];
    int cnts [5];
    adj_rows = '{default: '0};
    removed_set = '0;
    seen_set = '0;
    span_count = 7'd64;
    cnts = '{64, 1, 5, 12, 64};
    dir_rows = '{
      '{'{gdt_pkg::CMD_DFS, 6'd0, 6'd0}, 1'b1, '{6'd0, 1'b0}},
      '{'{gdt_pkg::CMD_BFS, 6'd0, 6'd0}, 1'b1, '{6'd0, 1'b0}},
      '{'{gdt_pkg::CMD_ADD_EDGE, 6'd0, 6'd63}, 1'b0, '0},
      '{'{gdt_pkg::CMD_ADD_EDGE, 6'd63, 6'd1}, 1'b0, '0},
      '{'{gdt_pkg::CMD_ADD_EDGE, 6'd5, 6'd5}, 1'b0, '0},
      '{'{gdt_pkg::CMD_ADD_EDGE, 6'd2, 6'd0}, 1'b0, '0},
      '{'{gdt_pkg::CMD_DFS, 6'd0, 6'd0}, 1'b0, '0},
      '{'{gdt_pkg::CMD_BFS, 6'd0, 6'd0}, 1'b0, '0},
      '{'{gdt_pkg::CMD_REMOVE, 6'd0, 6'd0}, 1'b0, '0},
      '{'{gdt_pkg::CMD_DFS, 6'd63, 6'd63}, 1'b1, '{6'd1, 1'b0}},
      '{'{gdt_pkg::CMD_BFS, 6'd0, 6'd0}, 1'b0, '0},
      '{'{gdt_pkg::CMD_REMOVE, 6'd63, 6'd0}, 1'b0, '0},
      '{'{gdt_pkg::CMD_ADD_EDGE, 6'd0, 6'd3}, 1'b0, '0},
      '{'{gdt_pkg::CMD_DFS, 6'd0, 6'd0}, 1'b0, '0},
      '{'{gdt_pkg::CMD_BFS, 6'd0, 6'd0}, 1'b0, '0}
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed && pending_visits.size() == 0) begin
        send_word(dir_rows[i].word);
        if (pending_visits.size() == 0 || pending_visits[0] !== dir_rows[i].first_result)
          report_mismatch($sformatf("directed row %0d first word", i));
      end else begin
        send_word(dir_rows[i].word);
      end
      drain_results();
    end
    write_count(7'd3);
    send_word('{gdt_pkg::CMD_ADD_EDGE, 6'd1, 6'd2});
    send_word('{gdt_pkg::CMD_ADD_EDGE, 6'd0, 6'd40});
    send_word('{gdt_pkg::CMD_DFS, 6'd0, 6'd0});
    send_word('{gdt_pkg::CMD_BFS, 6'd0, 6'd0});
    drain_results();
    write_count(7'd0);
    send_word('{gdt_pkg::CMD_ADD_EDGE, 6'd0, 6'd0});
    send_word('{gdt_pkg::CMD_DFS, 6'd0, 6'd0});
    drain_results();
    write_count(7'd127);
    send_word('{gdt_pkg::CMD_BFS, 6'd0, 6'd0});
    drain_results();
    hold_recv = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_recv = 1'b0;
      end
      repeat (3) send_word('{gdt_pkg::CMD_DFS, 6'd0, 6'd0});
    join
    drain_results();
    for (int ph = 0; ph < 5; ph++) begin
      write_count(cnts[ph][6:0]);
      case (ph)
        1: send_idle_pct = 81;
        2: begin send_idle_pct = 0; recv_stall_pct = 81; end
        3: begin send_idle_pct = 25; recv_stall_pct = 25; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (51) send_word(rand_word(trav_count()));
      drain_results();
    end
    if (pending_visits.size() != 0) report_mismatch("results never arrived");
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
